@@ sv/tle_pkg.sv @@
// shared constants, types and codes for the terminal line editor
package tle_pkg;

  localparam int LINE_LEN = 256;
  localparam int TAB_STOP = 8;

  localparam int ADDR_W = $clog2(LINE_LEN);
  localparam int CUR_W  = $clog2(LINE_LEN + 1);
  localparam int CNT_W  = $clog2(TAB_STOP + 1);
  localparam int PH_W   = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;

  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_DEL   = 8'd127;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_LINE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TAB,
    ST_TRIM_RD,
    ST_TRIM_CHK,
    ST_LINE
  } state_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  column;
    logic [7:0]  char_out;
    logic [8:0]  line_len;
    logic [15:0] line_number;
    logic        overflow;
    logic        last;
  } res_t;

endpackage

@@ sv/terminal_line_editor_unit.sv @@
// terminal line editor: line store in ram, cursor control, tab fill and newline trim
//
//  channel | signals                                   | words per item
//  --------+-------------------------------------------+-----------------------------
//  in      | in_valid in_ready char_in                 | one byte
//  out     | out_valid out_ready kind column char_out  | 0 to TAB_STOP results
//          | line_len line_number overflow last        |
//
// printable, backspace and carriage return bytes are handled without leaving idle
// a tab writes up to TAB_STOP fill spaces, stopping at a tab stop, and waits while the output stalls
// a newline trims trailing spaces above the cursor from the end, stopping at a non-space;
// one ram read per check, then the line result is emitted
// sync reset clears cursor, stored length, line counter and drop flag; ram is not cleared
// a stalled output register holds the sequencer until the word is taken
module terminal_line_editor_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  char_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        kind,
  output logic [7:0]  column,
  output logic [7:0]  char_out,
  output logic [8:0]  line_len,
  output logic [15:0] line_number,
  output logic        overflow,
  output logic        last
);

  localparam int CUR_W  = tle_pkg::CUR_W;
  localparam int ADDR_W = tle_pkg::ADDR_W;
  localparam int CNT_W  = tle_pkg::CNT_W;
  localparam int PH_W   = tle_pkg::PH_W;

  tle_pkg::state_t state, state_next;

  logic [CUR_W-1:0]  cursor, cursor_next;
  logic [CUR_W-1:0]  stored_len, stored_len_next;
  logic [CUR_W-1:0]  trim_end, trim_end_next;
  logic [PH_W-1:0]   phase, phase_next;
  logic [CNT_W-1:0]  tab_cnt, tab_cnt_next;
  logic [15:0]       line_counter, line_counter_next;
  logic              drop_flag, drop_flag_next;

  logic              wr_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;
  logic [7:0]        put_ch;
  logic              put;

  logic              push, can_push;
  tle_pkg::res_t     push_data, out_data;

  logic              cur_full;
  logic [CUR_W-1:0]  cursor_inc;
  logic [PH_W-1:0]   phase_inc;
  logic [PH_W-1:0]   put_phase;
  logic [CNT_W-1:0]  cnt_after;
  logic              tab_more;
  logic              printable;

  assign cur_full   = (cursor == CUR_W'(tle_pkg::LINE_LEN));
  assign cursor_inc = cursor + CUR_W'(1);
  assign phase_inc  = (phase == PH_W'(tle_pkg::TAB_STOP - 1)) ? '0 : phase + PH_W'(1);
  assign put_phase  = cur_full ? phase : phase_inc;
  assign cnt_after  = (state == tle_pkg::ST_IDLE) ? CNT_W'(1) : tab_cnt + CNT_W'(1);
  // fill continues until a tab stop or TAB_STOP spaces
  assign tab_more   = (put_phase != '0) && (cnt_after < CNT_W'(tle_pkg::TAB_STOP));
  assign printable  = (char_in >= tle_pkg::CH_SPACE) && (char_in <= tle_pkg::CH_TILDE);
  assign rd_addr    = ADDR_W'(trim_end - CUR_W'(1));

  always_comb begin
    state_next        = state;
    cursor_next       = cursor;
    stored_len_next   = stored_len;
    trim_end_next     = trim_end;
    phase_next        = phase;
    tab_cnt_next      = tab_cnt;
    line_counter_next = line_counter;
    drop_flag_next    = drop_flag;
    in_ready          = 1'b0;
    put               = 1'b0;
    put_ch            = tle_pkg::CH_SPACE;
    push              = 1'b0;
    push_data         = '0;
    push_data.line_number = line_counter;

    case (state)
      tle_pkg::ST_IDLE: begin
        in_ready = can_push;
        if (in_valid && can_push) begin
          if (char_in == tle_pkg::CH_BS || char_in == tle_pkg::CH_DEL) begin
            if (cursor != '0) begin
              cursor_next = cursor - CUR_W'(1);
              phase_next  = (phase == '0) ? PH_W'(tle_pkg::TAB_STOP - 1) : phase - PH_W'(1);
            end
          end else if (char_in == tle_pkg::CH_CR) begin
            cursor_next = '0;
            phase_next  = '0;
          end else if (char_in == tle_pkg::CH_TAB) begin
            put            = 1'b1;
            push_data.last = !tab_more;
            tab_cnt_next   = cnt_after;
            if (tab_more) begin
              state_next = tle_pkg::ST_TAB;
            end
          end else if (char_in == tle_pkg::CH_LF) begin
            trim_end_next = stored_len;
            state_next    = tle_pkg::ST_TRIM_RD;
          end else if (printable) begin
            put            = 1'b1;
            put_ch         = char_in;
            push_data.last = 1'b1;
          end
        end
      end
      tle_pkg::ST_TAB: begin
        if (can_push) begin
          put            = 1'b1;
          push_data.last = !tab_more;
          tab_cnt_next   = cnt_after;
          if (!tab_more) begin
            state_next = tle_pkg::ST_IDLE;
          end
        end
      end
      tle_pkg::ST_TRIM_RD: begin
        // trailing spaces are trimmed only above the cursor
        if ({1'b0, trim_end} > ({1'b0, cursor} + (CUR_W + 1)'(1))) begin
          state_next = tle_pkg::ST_TRIM_CHK;
        end else begin
          state_next = tle_pkg::ST_LINE;
        end
      end
      tle_pkg::ST_TRIM_CHK: begin
        if (rd_data == tle_pkg::CH_SPACE) begin
          trim_end_next = trim_end - CUR_W'(1);
          state_next    = tle_pkg::ST_TRIM_RD;
        end else begin
          state_next = tle_pkg::ST_LINE;
        end
      end
      tle_pkg::ST_LINE: begin
        if (can_push) begin
          push               = 1'b1;
          push_data.kind     = tle_pkg::KIND_LINE;
          push_data.char_out = tle_pkg::CH_LF;
          push_data.line_len = 9'(trim_end);
          push_data.overflow = drop_flag;
          push_data.last     = 1'b1;
          line_counter_next  = line_counter + 16'd1;
          cursor_next        = '0;
          phase_next         = '0;
          stored_len_next    = '0;
          drop_flag_next     = 1'b0;
          state_next         = tle_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tle_pkg::ST_IDLE;
      end
    endcase

    // shared character write path
    if (put) begin
      push               = 1'b1;
      push_data.kind     = tle_pkg::KIND_CHAR;
      push_data.column   = 8'(cursor);
      push_data.char_out = put_ch;
      push_data.overflow = cur_full;
      if (cur_full) begin
        drop_flag_next = 1'b1;
      end else begin
        cursor_next = cursor_inc;
        phase_next  = phase_inc;
        if (cursor_inc > stored_len) begin
          stored_len_next = cursor_inc;
        end
      end
    end
  end

  assign wr_en = put && !cur_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= tle_pkg::ST_IDLE;
      cursor       <= '0;
      stored_len   <= '0;
      phase        <= '0;
      tab_cnt      <= '0;
      line_counter <= '0;
      drop_flag    <= 1'b0;
    end else begin
      state        <= state_next;
      cursor       <= cursor_next;
      stored_len   <= stored_len_next;
      phase        <= phase_next;
      tab_cnt      <= tab_cnt_next;
      line_counter <= line_counter_next;
      drop_flag    <= drop_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    trim_end <= trim_end_next;
  end

  tle_ram #(
    .WIDTH(8),
    .DEPTH(tle_pkg::LINE_LEN)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (ADDR_W'(cursor)),
    .wr_data (put_ch),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  tle_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .can_push  (can_push),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign kind        = out_data.kind;
  assign column      = out_data.column;
  assign char_out    = out_data.char_out;
  assign line_len    = out_data.line_len;
  assign line_number = out_data.line_number;
  assign overflow    = out_data.overflow;
  assign last        = out_data.last;

  a_cursor_in_extent: assert property (@(posedge clk) disable iff (rst)
    (cursor <= stored_len) && (stored_len <= CUR_W'(tle_pkg::LINE_LEN)))
    else $error("cursor or stored length out of range");

  a_ready_only_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (state == tle_pkg::ST_IDLE))
    else $error("input taken outside idle");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (cursor < CUR_W'(tle_pkg::LINE_LEN)))
    else $error("line store write past capacity");

  a_line_clears: assert property (@(posedge clk) disable iff (rst)
    (state == tle_pkg::ST_LINE && can_push) |=>
      (cursor == '0 && stored_len == '0 && !drop_flag && state == tle_pkg::ST_IDLE))
    else $error("line state not cleared after newline");

endmodule

@@ sv/tle_ram.sv @@
// generic single-clock ram, one write port, one registered read port
module tle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ sv/tle_obuf.sv @@
// one-entry output register for result words
module tle_obuf (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tle_pkg::res_t push_data,
  output logic          can_push,
  output logic          out_valid,
  input  logic          out_ready,
  output tle_pkg::res_t out_data
);

  logic full;

  assign can_push  = !full || out_ready;
  assign out_valid = full;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (push) begin
      full <= 1'b1;
    end else if (out_ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_data <= push_data;
    end
  end

endmodule
